// ----- hw/rtl/mtmq_pkg.sv -----
// Shared types and constants for the message tag match queue.
// Field widths, status and state codes, result record and register map.
// No dependencies.
package mtmq_pkg;

	localparam int COMM_W      = 32;
	localparam int TAG_W       = 16;
	localparam int SRC_W       = 16;
	localparam int HANDLE_W    = 8;
	localparam int COUNT_W     = 21;
	localparam int DTYPE_W     = 16;
	localparam int BYTES_W     = 28;
	localparam int KEY_W       = COMM_W + TAG_W + SRC_W;
	localparam int ESIZE_LSB   = 8;
	localparam int ESIZE_W     = 8;
	localparam int PROD_W      = COUNT_W + ESIZE_W;

	// config port
	localparam int DATA_W      = 32;
	localparam int ADDR_W      = 3;
	localparam int REG_IDX_LSB = 2;
	localparam int REG_IDX_W   = ADDR_W - REG_IDX_LSB;

	localparam logic [REG_IDX_W-1:0] REG_WORLD_COMM = REG_IDX_W'(0);
	localparam logic [COMM_W-1:0]    WORLD_COMM_RST = 32'h4400_0000;

	typedef enum logic {
		OP_ARRIVE = 1'b0,
		OP_RECV   = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		STS_QUEUED    = 3'd0,
		STS_DELIVERED = 3'd1,
		STS_WAITING   = 3'd2,
		STS_DROPPED   = 3'd3,
		STS_BAD_COMM  = 3'd4,
		STS_DUP_RECV  = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SCAN,
		ST_SCAN_END,
		ST_RESOLVE,
		ST_AGE,
		ST_AGE_END,
		ST_FINISH
	} state_t;

	typedef struct packed {
		status_t              status;
		logic [HANDLE_W-1:0]  handle;
		logic [SRC_W-1:0]     source;
		logic [TAG_W-1:0]     tag;
		logic [BYTES_W-1:0]   bytes;
	} result_t;

endpackage

// ----- hw/rtl/message_tag_match_queue.sv -----
// Message tag match queue: unexpected-message table plus one waiting receive.
// Depends on mtmq_pkg and mtmq_apb.
//
// One transaction is handled at a time. The unexpected-message table is a
// single-port-read, single-port-write RAM of QUEUE_ENTRIES words (key, payload
// handle, arrival rank) scanned one entry per clock; that read port sets the
// rate. A bad communicator, an arrival that meets the waiting receive, or a
// second receive goes from the check step straight to the finish step. Other
// arrivals and receives scan the whole table. A receive that removes an entry
// makes an extra pass over the table, renumbering the arrival ranks of younger
// entries. A finished result sits in an output register, so the next
// transaction is accepted while it waits to be taken.
module message_tag_match_queue #(
	parameter int QUEUE_ENTRIES = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [mtmq_pkg::ADDR_W-1:0]     paddr,
	input  logic [mtmq_pkg::DATA_W-1:0]     pwdata,
	output logic [mtmq_pkg::DATA_W-1:0]     prdata,
	output logic                            pready,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            op,
	input  logic [mtmq_pkg::COMM_W-1:0]     comm,
	input  logic [mtmq_pkg::TAG_W-1:0]      tag,
	input  logic [mtmq_pkg::SRC_W-1:0]      source,
	input  logic [mtmq_pkg::HANDLE_W-1:0]   payload_handle,
	input  logic [mtmq_pkg::COUNT_W-1:0]    elem_count,
	input  logic [mtmq_pkg::DTYPE_W-1:0]    datatype,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [2:0]                      status,
	output logic [mtmq_pkg::HANDLE_W-1:0]   match_handle,
	output logic [mtmq_pkg::SRC_W-1:0]      match_source,
	output logic [mtmq_pkg::TAG_W-1:0]      match_tag,
	output logic [mtmq_pkg::BYTES_W-1:0]    byte_count
);
	import mtmq_pkg::*;

	localparam int IDX_W  = (QUEUE_ENTRIES > 1) ? $clog2(QUEUE_ENTRIES) : 1;
	localparam int CNT_W  = $clog2(QUEUE_ENTRIES + 1);
	localparam int WORD_W = KEY_W + HANDLE_W + IDX_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_ENTRIES - 1);

	state_t state_q, state_d;

	logic [COMM_W-1:0]   world_comm;

	// latched transaction
	op_t                 op_q;
	logic [KEY_W-1:0]    key_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [PROD_W-1:0]   prod_q;
	logic [BYTES_W-1:0]  bytes_q;

	// waiting receive
	logic                wait_valid_q;
	logic [KEY_W-1:0]    wait_key_q;
	logic [BYTES_W-1:0]  wait_bytes_q;

	// table
	logic [QUEUE_ENTRIES-1:0] valid_q;
	logic [WORD_W-1:0]   mem_q [QUEUE_ENTRIES];
	logic [WORD_W-1:0]   rd_data_s1;
	logic [IDX_W-1:0]    idx_q;
	logic                rd_en;
	logic                wr_en;
	logic [IDX_W-1:0]    wr_idx;
	logic [WORD_W-1:0]   wr_data;

	logic                rd_s1;
	logic                age_pass_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic                vbit_s1;
	logic [KEY_W-1:0]    rd_key;
	logic [HANDLE_W-1:0] rd_handle;
	logic [IDX_W-1:0]    rd_age;

	// scan trackers
	logic                found_q;
	logic [IDX_W-1:0]    best_idx_q;
	logic [IDX_W-1:0]    best_age_q;
	logic [HANDLE_W-1:0] best_handle_q;
	logic                free_found_q;
	logic [IDX_W-1:0]    free_idx_q;
	logic [CNT_W-1:0]    used_q;

	result_t             res_d;
	result_t             res_q;
	result_t             out_q;
	logic                out_valid_q;

	logic                in_fire;
	logic                load_out;
	logic                comm_ok;
	logic                wait_hit;
	logic                early_done;
	logic                scan_eval;
	logic                key_match;

	mtmq_apb u_apb (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.world_comm (world_comm)
	);

	assign comm_ok    = (key_q[KEY_W-1 -: COMM_W] == world_comm);
	assign wait_hit   = wait_valid_q && (wait_key_q == key_q);
	assign early_done = !comm_ok
		|| (op_q == OP_ARRIVE && wait_hit)
		|| (op_q == OP_RECV && wait_valid_q);

	assign rd_key    = rd_data_s1[WORD_W-1 -: KEY_W];
	assign rd_handle = rd_data_s1[IDX_W +: HANDLE_W];
	assign rd_age    = rd_data_s1[IDX_W-1:0];
	assign scan_eval = rd_s1 && !age_pass_s1;
	assign key_match = vbit_s1 && (rd_key == key_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (in_fire) state_d = ST_CHECK;
			ST_CHECK:    state_d = early_done ? ST_FINISH : ST_SCAN;
			ST_SCAN:     if (idx_q == LAST_IDX) state_d = ST_SCAN_END;
			ST_SCAN_END: state_d = ST_RESOLVE;
			ST_RESOLVE:  state_d = (op_q == OP_RECV && found_q) ? ST_AGE : ST_FINISH;
			ST_AGE:      if (idx_q == LAST_IDX) state_d = ST_AGE_END;
			ST_AGE_END:  state_d = ST_FINISH;
			ST_FINISH:   if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_ready = 1'b0;
		rd_en    = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE:   in_ready = 1'b1;
			ST_SCAN:   rd_en = 1'b1;
			ST_AGE:    rd_en = 1'b1;
			ST_FINISH: load_out = !out_valid_q || out_ready;
			default:   ;
		endcase
	end

	assign in_fire = in_valid & in_ready;

	// table write: insert on resolve, or rank decrement during the age pass
	always_comb begin
		wr_en   = 1'b0;
		wr_idx  = free_idx_q;
		wr_data = {key_q, handle_q, used_q[IDX_W-1:0]};
		if (state_q == ST_RESOLVE && op_q == OP_ARRIVE && free_found_q) begin
			wr_en = 1'b1;
		end else if (rd_s1 && age_pass_s1 && vbit_s1 && rd_age > best_age_q) begin
			wr_en   = 1'b1;
			wr_idx  = idx_s1;
			wr_data = {rd_key, rd_handle, rd_age - 1'b1};
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= mem_q[idx_q];
		end
		if (wr_en) begin
			mem_q[wr_idx] <= wr_data;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			valid_q      <= '0;
			wait_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			idx_q        <= '0;
			rd_s1        <= 1'b0;
			age_pass_s1  <= 1'b0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			used_q       <= '0;
		end else begin
			state_q     <= state_d;
			rd_s1       <= rd_en;
			age_pass_s1 <= (state_q == ST_AGE);

			if (rd_en) begin
				idx_q <= (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
			end else begin
				idx_q <= '0;
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (state_q == ST_CHECK) begin
				found_q      <= 1'b0;
				free_found_q <= 1'b0;
				used_q       <= '0;
				if (comm_ok && op_q == OP_ARRIVE && wait_hit) begin
					wait_valid_q <= 1'b0;
				end
			end

			if (scan_eval) begin
				if (vbit_s1) begin
					used_q <= used_q + 1'b1;
				end else if (!free_found_q) begin
					free_found_q <= 1'b1;
				end
				if (key_match && (!found_q || rd_age < best_age_q)) begin
					found_q <= 1'b1;
				end
			end

			if (state_q == ST_RESOLVE) begin
				if (op_q == OP_ARRIVE) begin
					if (free_found_q) begin
						valid_q[free_idx_q] <= 1'b1;
					end
				end else if (found_q) begin
					valid_q[best_idx_q] <= 1'b0;
				end else begin
					wait_valid_q <= 1'b1;
				end
			end
		end
	end

	// result of the check step or of the resolve step
	always_comb begin
		res_d = '0;
		if (state_q == ST_CHECK) begin
			if (!comm_ok) begin
				res_d.status = STS_BAD_COMM;
			end else if (op_q == OP_ARRIVE && wait_hit) begin
				res_d.status = STS_DELIVERED;
				res_d.handle = handle_q;
				res_d.source = key_q[SRC_W-1:0];
				res_d.tag    = key_q[SRC_W +: TAG_W];
				res_d.bytes  = wait_bytes_q;
			end else if (op_q == OP_RECV && wait_valid_q) begin
				res_d.status = STS_DUP_RECV;
			end
		end else if (op_q == OP_ARRIVE) begin
			res_d.status = free_found_q ? STS_QUEUED : STS_DROPPED;
		end else if (found_q) begin
			res_d.status = STS_DELIVERED;
			res_d.handle = best_handle_q;
			res_d.source = key_q[SRC_W-1:0];
			res_d.tag    = key_q[SRC_W +: TAG_W];
			res_d.bytes  = bytes_q;
		end else begin
			res_d.status = STS_WAITING;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		idx_s1  <= idx_q;
		vbit_s1 <= valid_q[idx_q];

		if (in_fire) begin
			op_q     <= op_t'(op);
			key_q    <= {comm, tag, source};
			handle_q <= payload_handle;
			prod_q   <= PROD_W'(elem_count) * PROD_W'(datatype[ESIZE_LSB +: ESIZE_W]);
		end

		if (scan_eval) begin
			if (!vbit_s1 && !free_found_q) begin
				free_idx_q <= idx_s1;
			end
			if (key_match && (!found_q || rd_age < best_age_q)) begin
				best_idx_q    <= idx_s1;
				best_age_q    <= rd_age;
				best_handle_q <= rd_handle;
			end
		end

		if (state_q == ST_CHECK) begin
			// saturate the byte count
			bytes_q <= prod_q[PROD_W-1] ? '1 : prod_q[BYTES_W-1:0];
		end

		if (state_q == ST_CHECK || state_q == ST_RESOLVE) begin
			res_q <= res_d;
		end

		if (state_q == ST_RESOLVE && op_q == OP_RECV && !found_q) begin
			wait_key_q   <= key_q;
			wait_bytes_q <= bytes_q;
		end

		if (load_out) begin
			out_q <= res_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_q.status;
	assign match_handle = out_q.handle;
	assign match_source = out_q.source;
	assign match_tag    = out_q.tag;
	assign byte_count   = out_q.bytes;

endmodule

// ----- hw/rtl/mtmq_apb.sv -----
// Configuration register block: APB-style write/read of the world communicator.
// Depends on mtmq_pkg.
module mtmq_apb (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mtmq_pkg::ADDR_W-1:0]   paddr,
	input  logic [mtmq_pkg::DATA_W-1:0]   pwdata,
	output logic [mtmq_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output logic [mtmq_pkg::COMM_W-1:0]   world_comm
);
	import mtmq_pkg::*;

	logic [REG_IDX_W-1:0] reg_idx;
	logic [COMM_W-1:0]    world_comm_q;
	logic                 wr_fire;

	assign reg_idx = paddr[ADDR_W-1:REG_IDX_LSB];
	assign pready  = 1'b1;
	assign wr_fire = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			world_comm_q <= WORLD_COMM_RST;
		end else if (wr_fire && reg_idx == REG_WORLD_COMM) begin
			world_comm_q <= pwdata[COMM_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == REG_WORLD_COMM) begin
			prdata = DATA_W'(world_comm_q);
		end
	end

	assign world_comm = world_comm_q;

endmodule
